>>> hw/rtl/cnm_pkg.sv
`default_nettype none
package cnm_pkg;
  localparam int unsigned MAP_DEPTH_DEF = 65536;
  localparam logic [15:0] CLIP_RESET = 16'd256;
  localparam logic [47:0] SUM_MAX = {48{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic rd_start;
    logic div1_start;
    logic sqrt_start;
    logic mul_go;
    logic div2_start;
    logic finish;
  } cnm_ctrl_t;

  typedef struct packed {
    logic in_range;
    logic div_done;
    logic sqrt_done;
  } cnm_stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/cnm_if.sv
`default_nettype none
interface cnm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] sample;
  logic [15:0] index;
  modport source (output valid, command, sample, index, input ready);
  modport sink (input valid, command, sample, index, output ready);
endinterface

interface cnm_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] normalized;
  logic        status;
  modport source (output valid, normalized, status, input ready);
  modport sink (input valid, normalized, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cnm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cnm_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo,
  output logic               done
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[DW-1:0], quo_r[NW-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign quo = quo_r;
  assign done = busy_r && (cnt_r == CW'(1));
endmodule
`default_nettype wire

>>> hw/rtl/cnm_sqrt.sv
`default_nettype none
// Digit-by-digit square root, one result bit per cycle.
module cnm_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [55:0] val,
  output logic      [27:0] root,
  output logic             done
);
  logic [55:0] v_r, v_nxt;
  logic [29:0] rem_r, rem_nxt;
  logic [27:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [29:0] trial, tst;

  always_comb begin
    v_nxt = v_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == 5'd1);
    trial = {rem_r[27:0], v_r[55:54]};
    tst = {res_r, 2'b01};
    if (start) begin
      v_nxt = val;
      rem_nxt = '0;
      res_nxt = '0;
      cnt_nxt = 5'd28;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[53:0], 2'b00};
      if (trial >= tst) begin
        rem_nxt = trial - tst;
        res_nxt = {res_r[26:0], 1'b1};
      end else begin
        rem_nxt = trial;
        res_nxt = {res_r[26:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    v_r <= v_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign root = res_r;
  assign done = done_r;
endmodule
`default_nettype wire

>>> hw/rtl/cnm_datapath.sv
`default_nettype none
module cnm_datapath #(
  parameter int unsigned MAP_DEPTH = cnm_pkg::MAP_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cnm_pkg::cnm_ctrl_t ctrl,
  output cnm_pkg::cnm_stat_t     stat,
  input  wire logic [31:0]       in_sample,
  input  wire logic [15:0]       in_index,
  input  wire logic [15:0]       clip_ratio,
  output logic      [16:0]       res_norm
);
  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(MAP_DEPTH + 1);

  logic [31:0] mem [MAP_DEPTH];
  logic [31:0] rd_data_r;
  logic [47:0] sum_r;
  logic [CNTW-1:0] cnt_r;
  logic [31:0] least_r, great_r;
  logic [47:0] sum_add;
  logic [48:0] sum_wide;
  logic        full;

  logic [47:0] div_num;
  logic [31:0] div_den;
  logic [47:0] div_q;
  logic        div_start;
  logic [27:0] root;
  logic [43:0] prod_r;
  logic [31:0] vmax_r, lo_r, hi_r, c_r;
  logic [31:0] vm, lo_c, hi_c, cc, c2;

  assign full = (cnt_r >= CNTW'(MAP_DEPTH));
  assign sum_wide = {1'b0, sum_r} + {17'd0, in_sample};
  assign sum_add = sum_wide[48] ? cnm_pkg::SUM_MAX : sum_wide[47:0];
  assign stat.in_range = (32'(in_index) < 32'(cnt_r))
                         && (32'(in_index) < 32'(MAP_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      sum_r <= '0;
      cnt_r <= '0;
      least_r <= '1;
      great_r <= '0;
    end else if (ctrl.load && !full) begin
      sum_r <= sum_add;
      cnt_r <= cnt_r + 1'b1;
      if (in_sample < least_r) least_r <= in_sample;
      if (in_sample > great_r) great_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && !full) mem[cnt_r[AW-1:0]] <= in_sample;
    if (ctrl.rd_start) rd_data_r <= mem[AW'(in_index)];
  end

  assign vm = (32'(prod_r >> 8) > great_r || |prod_r[43:40]) ? great_r : prod_r[39:8];
  assign lo_c = (least_r < vm) ? least_r : vm;
  assign hi_c = (great_r < vm) ? great_r : vm;
  assign cc = (rd_data_r > vm) ? vm : rd_data_r;
  assign c2 = (cc < lo_c) ? lo_c : cc;

  always_ff @(posedge clk) begin
    if (ctrl.sqrt_start) prod_r <= '0;
    if (ctrl.mul_go) prod_r <= 44'(clip_ratio) * 44'(root);
    if (ctrl.div2_start) begin
      vmax_r <= vm;
      lo_r <= lo_c;
      hi_r <= hi_c;
      c_r <= c2;
    end
  end

  assign div_start = ctrl.div1_start || ctrl.div2_start;
  assign div_num = ctrl.div1_start ? sum_r : {c2 - lo_c, 16'd0};
  assign div_den = ctrl.div1_start ? 32'(cnt_r) : (hi_c - lo_c);

  cnm_div #(.NW(48), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(stat.div_done)
  );

  cnm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(ctrl.sqrt_start), .val({div_q, 8'd0}),
    .root(root), .done(stat.sqrt_done)
  );

  assign res_norm = (hi_r > lo_r) ? div_q[16:0] : 17'd0;

  logic unused_ok;
  assign unused_ok = ^{vmax_r, c_r, div_q[47:17]};
endmodule
`default_nettype wire

>>> hw/rtl/cnm_ctrl.sv
`default_nettype none
module cnm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [1:0]         in_command,
  input  wire cnm_pkg::cnm_stat_t stat,
  input  wire logic               out_ready,
  output logic                    in_ready,
  output cnm_pkg::cnm_ctrl_t      ctrl,
  output logic                    out_valid,
  output logic                    out_status,
  output logic                    norm_sel
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV1 = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_PREP = 7'b0010000,
    S_DIV2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic status_r, status_nxt;
  logic sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    sel_nxt = sel_r;
    ctrl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.clear = (in_command == cnm_pkg::CMD_CLEAR);
          ctrl.load = (in_command == cnm_pkg::CMD_LOAD);
          if (in_command == cnm_pkg::CMD_READ) begin
            if (stat.in_range) begin
              ctrl.rd_start = 1'b1;
              ctrl.div1_start = 1'b1;
              state_nxt = S_DIV1;
            end else begin
              status_nxt = 1'b1;
              sel_nxt = 1'b0;
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_DIV1: if (stat.div_done) state_nxt = S_SQRT;
      S_SQRT: begin
        ctrl.sqrt_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: if (stat.sqrt_done) begin
        ctrl.mul_go = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        ctrl.div2_start = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: if (stat.div_done) begin
        status_nxt = 1'b0;
        sel_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      status_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign norm_sel = sel_r;

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("accept while result pending");
  a_okpath: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !status_r) |-> sel_r)
    else $error("ok result without datapath result");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/clip_and_normalize_map.sv
`default_nettype none
// Clipped min-max normalization map. Load transactions append Q24.8 samples while
// the map has room; clear starts a new map; a read returns one Q1.16 result with
// status. The input stays ready after a load or clear. A read in range runs in turn
// the mean division, the start of the square root, 28 square-root steps, the
// registered multiply of the root by the clip ratio, the remap set-up and the remap
// division, the two divisions sharing one radix-2 divider. A read out of range presents its
// result the cycle after acceptance. The result is held until taken, and no new
// transaction is accepted before then, so one transaction is handled at a time.
module clip_and_normalize_map #(
  parameter int unsigned MAP_DEPTH = cnm_pkg::MAP_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cnm_in_if.sink           in_ch,
  cnm_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0] clip_r;
  cnm_pkg::cnm_ctrl_t ctrl;
  cnm_pkg::cnm_stat_t stat;
  logic [16:0] norm;
  logic status, sel, fire;

  always_ff @(posedge clk) begin
    if (!rst_n) clip_r <= cnm_pkg::CLIP_RESET;
    else if (cfg_we) clip_r <= cfg_wdata;
  end

  assign fire = in_ch.valid && in_ch.ready;

  cnm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(fire), .in_command(in_ch.command),
    .stat(stat), .out_ready(out_ch.ready), .in_ready(in_ch.ready), .ctrl(ctrl),
    .out_valid(out_ch.valid), .out_status(status), .norm_sel(sel)
  );

  cnm_datapath #(.MAP_DEPTH(MAP_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .in_sample(in_ch.sample),
    .in_index(in_ch.index), .clip_ratio(clip_r), .res_norm(norm)
  );

  assign out_ch.normalized = sel ? norm : 17'd0;
  assign out_ch.status = status;
endmodule
`default_nettype wire

>>> sim/cnm_checker.sv
`timescale 1ns / 1ps
module cnm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_sample,
  input  wire logic [15:0] in_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [16:0] out_normalized,
  input  wire logic        out_status,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);
  typedef struct packed {
    logic [16:0] normalized;
    logic        status;
  } norm_result_t;

  logic [31:0]  store_mem [0:65535];
  logic [47:0]  sum_q;
  logic [16:0]  count_q;
  logic [31:0]  least_q;
  logic [31:0]  greatest_q;
  logic [15:0]  ratio_q;
  norm_result_t pending_q [$];

  assign pending_count = pending_q.size();

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic norm_result_t predict_read(input logic [15:0] idx);
    norm_result_t r;
    logic [63:0] mean, root, vmax, lo, hi, c;
    r.normalized = '0;
    r.status = 1'b0;
    if ({1'b0, idx} >= count_q) begin
      r.status = 1'b1;
      return r;
    end
    mean = {16'd0, sum_q} / {47'd0, count_q};
    root = {32'd0, int_sqrt(mean << 8)};
    vmax = ({48'd0, ratio_q} * root) >> 8;
    if (vmax > greatest_q) vmax = greatest_q;
    lo = (least_q < vmax) ? least_q : vmax;
    hi = (greatest_q < vmax) ? greatest_q : vmax;
    c = store_mem[idx];
    if (c > vmax) c = vmax;
    if (c < lo) c = lo;
    if (hi > lo) r.normalized = 17'(((c - lo) << 16) / (hi - lo));
    return r;
  endfunction

  always @(posedge clk) begin
    norm_result_t exp_r;
    logic [48:0] acc;
    if (!rst_n) begin
      sum_q <= '0;
      count_q <= '0;
      least_q <= '1;
      greatest_q <= '0;
      ratio_q <= cnm_pkg::CLIP_RESET;
      fail_count <= 0;
      pending_q.delete();
    end else begin
      if (cfg_we) ratio_q <= cfg_wdata;
      if (in_valid && in_ready) begin
        case (cnm_pkg::cmd_t'(in_command))
          cnm_pkg::CMD_CLEAR: begin
            sum_q <= '0;
            count_q <= '0;
            least_q <= '1;
            greatest_q <= '0;
          end
          cnm_pkg::CMD_LOAD: begin
            if (count_q < 17'd65536) begin
              store_mem[count_q[15:0]] <= in_sample;
              count_q <= count_q + 17'd1;
              acc = {1'b0, sum_q} + {17'd0, in_sample};
              sum_q <= acc[48] ? cnm_pkg::SUM_MAX : acc[47:0];
              if (in_sample < least_q) least_q <= in_sample;
              if (in_sample > greatest_q) greatest_q <= in_sample;
            end
          end
          cnm_pkg::CMD_READ: pending_q.push_back(predict_read(in_index));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result normalized=%0d status=%0d", $time,
                   out_normalized, out_status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = pending_q.pop_front();
          if (exp_r.normalized !== out_normalized || exp_r.status !== out_status) begin
            $display({"%0t: mismatch expected normalized=%0d status=%0d ",
                      "actual normalized=%0d status=%0d"},
                     $time, exp_r.normalized, exp_r.status, out_normalized,
                     out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/clip_and_normalize_map_tb.sv
`timescale 1ns / 1ps
module clip_and_normalize_map_tb;
  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic quiet_mode;
  logic hold_off;
  int fail_count;
  int pending_count;
  int cycle_count;
  int load_count;

  cnm_in_if in_ch ();
  cnm_out_if out_ch ();

  clip_and_normalize_map uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  cnm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .in_sample(in_ch.sample), .in_index(in_ch.index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_normalized(out_ch.normalized), .out_status(out_ch.status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
      if (cycle_count > 400000) begin
        $display("FAIL clip_and_normalize_map");
        $finish;
      end
    end
  end

  // The receiver stalls at random, never during quiet stretches and always during a long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (quiet_mode) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 30);
    end
  end

  task automatic send(input cnm_pkg::cmd_t cmd, input logic [31:0] smp,
                      input logic [15:0] idx);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 30) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample <= smp;
    in_ch.index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (cmd == cnm_pkg::CMD_LOAD) load_count = load_count + 1;
    if (cmd == cnm_pkg::CMD_CLEAR) load_count = 0;
  endtask

  task automatic drain_and_set(input logic [15:0] ratio);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ratio;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      2: return $urandom_range(15);
      default: return $urandom_range(32'h000F_FFFF);
    endcase
  endfunction

  function automatic logic [15:0] rand_index();
    if ($urandom_range(9) == 0) return 16'($urandom);
    if (load_count == 0) return 16'($urandom_range(3));
    return 16'($urandom_range(32'(load_count)));
  endfunction

  initial begin
    int k;
    int phase;
    logic [15:0] ratios [5];
    ratios = '{16'd0, 16'd65535, 16'd128, 16'd512, 16'd256};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet_mode = 1'b0;
    hold_off = 1'b0;
    load_count = 0;
    in_ch.valid = 1'b0;
    in_ch.command = cnm_pkg::CMD_CLEAR;
    in_ch.sample = '0;
    in_ch.index = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(cnm_pkg::CMD_READ, 32'd0, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'hFFFF);
    send(cnm_pkg::CMD_LOAD, 32'd5, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd0);
    send(cnm_pkg::CMD_LOAD, 32'd5, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd1);
    send(cnm_pkg::CMD_LOAD, 32'hFFFF_FFFF, 16'd0);
    send(cnm_pkg::CMD_LOAD, 32'h0, 16'd0);
    send(cnm_pkg::CMD_NONE, 32'h1234, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd2);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd3);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd4);
    send(cnm_pkg::CMD_CLEAR, 32'd0, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd0);
    for (k = 0; k < 6; k++) send(cnm_pkg::CMD_LOAD, 32'hFFFF_FFFF, 16'd0);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd5);
    send(cnm_pkg::CMD_READ, 32'd0, 16'd0);
    send(cnm_pkg::CMD_CLEAR, 32'd0, 16'd0);

    for (phase = 0; phase < 5; phase++) begin
      drain_and_set(ratios[phase]);
      quiet_mode = (phase == 2);
      if (phase == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (800) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (k = 0; k < 110; k++) begin
        case ($urandom_range(19))
          0: send(cnm_pkg::CMD_CLEAR, $urandom, 16'($urandom));
          1: send(cnm_pkg::CMD_NONE, $urandom, 16'($urandom));
          2, 3, 4, 5, 6, 7, 8, 9: send(cnm_pkg::CMD_LOAD, rand_sample(), 16'($urandom));
          default: send(cnm_pkg::CMD_READ, $urandom, rand_index());
        endcase
      end
      quiet_mode = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS clip_and_normalize_map");
    end else begin
      $display("FAIL clip_and_normalize_map");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/cnm_pkg.sv
hw/rtl/cnm_if.sv
hw/rtl/cnm_div.sv
hw/rtl/cnm_sqrt.sv
hw/rtl/cnm_datapath.sv
hw/rtl/cnm_ctrl.sv
hw/rtl/clip_and_normalize_map.sv
sim/cnm_checker.sv
sim/clip_and_normalize_map_tb.sv
